/* hw/rtl/bts_pkg.sv */
// Shared types and constants for the batch tank sequencer.
package bts_pkg;

    typedef enum logic [1:0] {
        PH_FILL  = 2'd0,
        PH_HEAT  = 2'd1,
        PH_MIX   = 2'd2,
        PH_DRAIN = 2'd3
    } phase_t;

    localparam logic [2:0]  DEV_INLET       = 3'd0;
    localparam logic [2:0]  DEV_OUTLET      = 3'd1;
    localparam logic [2:0]  DEV_HEATER      = 3'd2;
    localparam logic [2:0]  DEV_MIXER       = 3'd4;
    localparam logic [15:0] MIX_TICKS_RESET = 16'd5000;
    localparam int          MAX_CMDS        = 3;

    typedef struct packed {
        logic [2:0] device;
        logic       switch_on;
    } cmd_t;

    // one scan's commands; count is 1..3, cmd[0] goes out first
    typedef struct packed {
        logic [1:0]          count;
        cmd_t [MAX_CMDS-1:0] cmd;
    } group_t;

endpackage

/* hw/rtl/batch_tank_sequencer.sv */
// Batch tank sequencer top level: front end, group queue, back end.
//
// Input side is a queue: drive kind and the sensor bits with push; the word is
// taken at a clock edge where push is high and full is low. kind 0 is a timer
// tick (advances the mix counter, no output); kind 1 is a scan pass that runs
// fill, heat, mix and drain in order and yields zero to three commands.
// Output side is a queue: while empty is low, device/switch_on/last show the
// oldest command; pop high at a clock edge takes it. last marks the final
// command of a scan.
// mix_ticks is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. The first
// command of a scan passes through the group queue and then the output
// register before it is visible. Throughput: one input word per cycle while
// the group queue has room; the back end sends one command per cycle while
// the receiver pops. A stalled receiver holds the output word; groups collect
// in the QUEUE_DEPTH-entry queue and then full rises. Reset returns to the
// fill phase with all actuators off, mix_ticks 5000, and both queues empty.
module batch_tank_sequencer
    import bts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic        level_high,
    input  logic        level_low,
    input  logic        is_hot,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  device,
    output logic        switch_on,
    output logic        last
);

    logic   accept;
    logic   grp_push;
    group_t grp;
    group_t q_head;
    logic   q_empty;
    logic   q_pop;

    assign accept = push && !full;

    bts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .kind       (kind),
        .level_high (level_high),
        .level_low  (level_low),
        .is_hot     (is_hot),
        .grp_push   (grp_push),
        .grp        (grp)
    );

    bts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (grp_push),
        .wdata (grp),
        .pop   (q_pop),
        .rdata (q_head),
        .full  (full),
        .empty (q_empty)
    );

    bts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .device    (device),
        .switch_on (switch_on),
        .last      (last)
    );

endmodule

/* hw/rtl/bts_front.sv */
// Front end: takes ticks and scans, runs the phase logic, emits command groups.
module bts_front
    import bts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        accept,
    input  logic        kind,
    input  logic        level_high,
    input  logic        level_low,
    input  logic        is_hot,
    output logic        grp_push,
    output group_t      grp
);

    logic [15:0] mix_ticks_reg;
    phase_t      phase_reg, phase_next;
    logic        inlet_open_reg, inlet_open_next;
    logic        mixer_running_reg, mixer_running_next;
    logic [15:0] mix_count_reg, mix_count_next;
    logic        mix_done_reg, mix_done_next;
    logic [15:0] tick_sum;
    logic [1:0]  n;

    assign tick_sum = mix_count_reg + 16'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        inlet_open_next    = inlet_open_reg;
        mixer_running_next = mixer_running_reg;
        mix_count_next     = mix_count_reg;
        mix_done_next      = mix_done_reg;
        n                  = 2'd0;
        grp                = '0;
        if (accept)
        begin
            if (!kind)
            begin
                if (tick_sum >= mix_ticks_reg)
                begin
                    mix_done_next  = 1'b1;
                    mix_count_next = 16'd0;
                end
                else
                begin
                    mix_count_next = tick_sum;
                end
            end
            else
            begin
                if (phase_next == PH_FILL)
                begin
                    if (!level_high)
                    begin
                        if (!inlet_open_next)
                        begin
                            grp.cmd[n]      = '{DEV_INLET, 1'b1};
                            n               = n + 2'd1;
                            inlet_open_next = 1'b1;
                        end
                    end
                    else
                    begin
                        grp.cmd[n]      = '{DEV_INLET, 1'b0};
                        n               = n + 2'd1;
                        inlet_open_next = 1'b0;
                        phase_next      = PH_HEAT;
                    end
                end
                if (phase_next == PH_HEAT)
                begin
                    if (!is_hot)
                    begin
                        grp.cmd[n] = '{DEV_HEATER, 1'b1};
                        n          = n + 2'd1;
                    end
                    else
                    begin
                        grp.cmd[n] = '{DEV_HEATER, 1'b0};
                        n          = n + 2'd1;
                        phase_next = PH_MIX;
                    end
                end
                if (phase_next == PH_MIX)
                begin
                    if (!mixer_running_next)
                    begin
                        mix_done_next      = 1'b0;
                        mix_count_next     = 16'd0;
                        grp.cmd[n]         = '{DEV_MIXER, 1'b1};
                        n                  = n + 2'd1;
                        mixer_running_next = 1'b1;
                    end
                    if (mix_done_next)
                    begin
                        grp.cmd[n]         = '{DEV_MIXER, 1'b0};
                        n                  = n + 2'd1;
                        mixer_running_next = 1'b0;
                        mix_done_next      = 1'b0;
                        phase_next         = PH_DRAIN;
                    end
                end
                if (phase_next == PH_DRAIN)
                begin
                    if (level_high)
                    begin
                        grp.cmd[n] = '{DEV_OUTLET, 1'b1};
                        n          = n + 2'd1;
                    end
                    else if (!level_low)
                    begin
                        grp.cmd[n] = '{DEV_OUTLET, 1'b0};
                        n          = n + 2'd1;
                        phase_next = PH_FILL;
                    end
                end
            end
        end
        grp.count = n;
        grp_push  = accept && kind && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_ticks_reg     <= MIX_TICKS_RESET;
            phase_reg         <= PH_FILL;
            inlet_open_reg    <= 1'b0;
            mixer_running_reg <= 1'b0;
            mix_count_reg     <= 16'd0;
            mix_done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mix_ticks_reg <= cfg_wdata;
            end
            phase_reg         <= phase_next;
            inlet_open_reg    <= inlet_open_next;
            mixer_running_reg <= mixer_running_next;
            mix_count_reg     <= mix_count_next;
            mix_done_reg      <= mix_done_next;
        end
    end

endmodule

/* hw/rtl/bts_queue.sv */
// Short queue of command groups between front and back.
module bts_queue
    import bts_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  group_t wdata,
    input  logic   pop,
    output group_t rdata,
    output logic   full,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/bts_back.sv */
// Back end: splits command groups into single words in an output register.
module bts_back
    import bts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  group_t     q_head,
    input  logic       q_empty,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [2:0] device,
    output logic       switch_on,
    output logic       last
);

    logic       out_valid_reg;
    logic [2:0] device_reg;
    logic       switch_on_reg;
    logic       last_reg;
    logic [1:0] pos_reg;
    logic       take;
    logic       load;
    logic       is_last;

    assign take    = !out_valid_reg || pop;
    assign load    = take && !q_empty;
    assign is_last = (pos_reg == q_head.count - 2'd1);
    assign q_pop   = load && is_last;

    assign empty     = !out_valid_reg;
    assign device    = device_reg;
    assign switch_on = switch_on_reg;
    assign last      = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            device_reg    <= q_head.cmd[pos_reg].device;
            switch_on_reg <= q_head.cmd[pos_reg].switch_on;
            last_reg      <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= is_last ? 2'd0 : pos_reg + 2'd1;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* bench/batch_tank_sequencer_test.sv */
// Self-checking testbench for the batch tank sequencer.
module batch_tank_sequencer_test;
    import bts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic kind;
        logic level_high;
        logic level_low;
        logic is_hot;
    } tank_word_t;

    typedef struct packed {
        logic [2:0] device;
        logic       switch_on;
        logic       last;
    } tank_cmd_t;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_wdata  = '0;
    logic        push       = 1'b0;
    logic        full;
    logic        kind       = 1'b0;
    logic        level_high = 1'b0;
    logic        level_low  = 1'b0;
    logic        is_hot     = 1'b0;
    logic        empty;
    logic        pop        = 1'b0;
    logic [2:0]  device;
    logic        switch_on;
    logic        last;

    batch_tank_sequencer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .level_high (level_high),
        .level_low  (level_low),
        .is_hot     (is_hot),
        .empty      (empty),
        .pop        (pop),
        .device     (device),
        .switch_on  (switch_on),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timeout, sequencer stopped making progress", $realtime);
        $display("status: fail");
        $finish;
    end

    // words waiting for the driver, and commands the tank model predicts
    tank_word_t word_q[$];
    tank_cmd_t  cmd_expect[$];
    tank_word_t word_on_bus = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_recv = 1'b0;
    logic stall_go  = 1'b0;

    int words_taken = 0;
    int scans_taken = 0;
    int cmds_seen   = 0;
    int errors      = 0;
    int settings_run = 1;

    // tank model state
    phase_t      tank_phase    = PH_FILL;
    logic        inlet_open    = 1'b0;
    logic        outlet_open   = 1'b0;
    logic        mixer_running = 1'b0;
    logic [15:0] mix_count     = '0;
    logic        mix_done      = 1'b0;
    logic [15:0] mix_ticks_r   = MIX_TICKS_RESET;

    function automatic tank_cmd_t make_cmd(logic [2:0] dev, logic on);
        tank_cmd_t c;
        c.device = dev;
        c.switch_on = on;
        c.last = 1'b0;
        return c;
    endfunction

    task automatic predict_tank_word(input tank_word_t w);
        tank_cmd_t cmds[$];
        if (w.kind == KIND_TICK)
        begin
            mix_count = mix_count + 16'd1;
            if (mix_count >= mix_ticks_r)
            begin
                mix_done = 1'b1;
                mix_count = '0;
            end
            return;
        end
        if (tank_phase == PH_FILL)
        begin
            if (!w.level_high)
            begin
                if (!inlet_open)
                begin
                    cmds.push_back(make_cmd(DEV_INLET, 1'b1));
                    inlet_open = 1'b1;
                end
            end
            else
            begin
                cmds.push_back(make_cmd(DEV_INLET, 1'b0));
                inlet_open = 1'b0;
                tank_phase = PH_HEAT;
            end
        end
        if (tank_phase == PH_HEAT)
        begin
            if (!w.is_hot)
                cmds.push_back(make_cmd(DEV_HEATER, 1'b1));
            else
            begin
                cmds.push_back(make_cmd(DEV_HEATER, 1'b0));
                tank_phase = PH_MIX;
            end
        end
        if (tank_phase == PH_MIX)
        begin
            if (!mixer_running)
            begin
                mix_done = 1'b0;
                mix_count = '0;
                cmds.push_back(make_cmd(DEV_MIXER, 1'b1));
                mixer_running = 1'b1;
            end
            if (mix_done)
            begin
                cmds.push_back(make_cmd(DEV_MIXER, 1'b0));
                mixer_running = 1'b0;
                mix_done = 1'b0;
                tank_phase = PH_DRAIN;
            end
        end
        // drain closing goes back to fill, which waits for the next scan
        if (tank_phase == PH_DRAIN)
        begin
            if (w.level_high)
            begin
                cmds.push_back(make_cmd(DEV_OUTLET, 1'b1));
                outlet_open = 1'b1;
            end
            else if (!w.level_low)
            begin
                cmds.push_back(make_cmd(DEV_OUTLET, 1'b0));
                outlet_open = 1'b0;
                tank_phase = PH_FILL;
            end
        end
        if (cmds.size() > 0)
            cmds[cmds.size()-1].last = 1'b1;
        foreach (cmds[i])
            cmd_expect.push_back(cmds[i]);
    endtask

    // driver: hold the word while full, otherwise offer the next one or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                predict_tank_word(word_on_bus);
                words_taken++;
                if (word_on_bus.kind == KIND_SCAN)
                    scans_taken++;
            end
            if (!(push && full))
            begin
                if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    word_on_bus <= word_q[0];
                    kind        <= word_q[0].kind;
                    level_high  <= word_q[0].level_high;
                    level_low   <= word_q[0].level_low;
                    is_hot      <= word_q[0].is_hot;
                    void'(word_q.pop_front());
                    push        <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: take commands at random and check them in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                cmds_seen++;
                if (cmd_expect.size() == 0)
                begin
                    $display("%0t: unexpected command: expected none,", $realtime,
                             " got dev %0d on %0b last %0b", device, switch_on, last);
                    errors++;
                end
                else
                begin
                    if (cmd_expect[0].device !== device || cmd_expect[0].switch_on !== switch_on
                        || cmd_expect[0].last !== last)
                    begin
                        $display("%0t: command mismatch:", $realtime,
                                 " expected dev %0d on %0b last %0b,", cmd_expect[0].device,
                                 cmd_expect[0].switch_on, cmd_expect[0].last,
                                 " got dev %0d on %0b last %0b", device, switch_on, last);
                        errors++;
                    end
                    void'(cmd_expect.pop_front());
                end
            end
            pop <= !hold_recv && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver stall so the group queue fills and full rises
    initial
    begin
        wait (stall_go);
        @(posedge clk);
        hold_recv <= 1'b1;
        repeat (80) @(posedge clk);
        hold_recv <= 1'b0;
    end

    task automatic add_word(logic k, logic hi, logic lo, logic hot);
        tank_word_t w;
        w.kind = k;
        w.level_high = hi;
        w.level_low = lo;
        w.is_hot = hot;
        word_q.push_back(w);
    endtask

    task automatic add_random_words(int count);
        repeat (count)
            add_word(($urandom_range(0, 99) < 40) ? KIND_TICK : KIND_SCAN,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    // idle means nothing queued, nothing offered and nothing outstanding
    task automatic wait_idle();
        while (word_q.size() != 0 || push || cmd_expect.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mix_ticks(logic [15:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        mix_ticks_r = value;
        settings_run++;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 85;

        // reset setting: fill, heat, then mixer starts and waits
        add_word(KIND_SCAN, 1'b0, 1'b0, 1'b0);
        add_word(KIND_SCAN, 1'b0, 1'b1, 1'b1);   // inlet already open: no word
        add_word(KIND_TICK, 1'b1, 1'b1, 1'b1);
        add_word(KIND_SCAN, 1'b1, 1'b0, 1'b0);
        add_word(KIND_SCAN, 1'b1, 1'b1, 1'b0);   // heater re-sent
        add_word(KIND_SCAN, 1'b1, 1'b1, 1'b1);
        add_word(KIND_TICK, 1'b0, 1'b0, 1'b0);
        add_word(KIND_TICK, 1'b0, 1'b0, 1'b0);
        add_word(KIND_SCAN, 1'b0, 1'b1, 1'b0);   // mixing not done

        // zero count: every tick ends mixing
        write_mix_ticks(16'd0);
        add_word(KIND_TICK, 1'b0, 1'b0, 1'b0);
        add_word(KIND_SCAN, 1'b1, 1'b1, 1'b0);
        add_word(KIND_SCAN, 1'b1, 1'b1, 1'b1);
        add_word(KIND_SCAN, 1'b0, 1'b1, 1'b0);
        add_word(KIND_SCAN, 1'b0, 1'b0, 1'b1);
        add_word(KIND_SCAN, 1'b1, 1'b1, 1'b1);   // three words in one scan

        write_mix_ticks(16'd1);
        add_word(KIND_TICK, 1'b0, 1'b0, 1'b0);
        add_word(KIND_SCAN, 1'b1, 1'b0, 1'b0);
        add_word(KIND_SCAN, 1'b0, 1'b0, 1'b0);
        add_word(KIND_SCAN, 1'b0, 1'b0, 1'b0);
        add_word(KIND_SCAN, 1'b1, 1'b1, 1'b1);

        write_mix_ticks(16'hFFFF);
        add_random_words(40);

        write_mix_ticks(16'($urandom_range(1, 4)));
        stall_go = 1'b1;
        add_random_words(110);

        write_mix_ticks(16'($urandom_range(2, 8)));
        send_idle_pct = 85;
        recv_idle_pct = 38;
        add_random_words(100);

        write_mix_ticks(16'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_words(100);

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Covered %0d words (%0d scans)", words_taken, scans_taken,
                 " over %0d mix_ticks settings, %0d commands checked.",
                 settings_run, cmds_seen);
        $display("Idle mixes: slow receiver, slow sender, full rate; one long output stall.");
        if (errors == 0 && cmd_expect.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d commands never arrived", errors, cmd_expect.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
